>>> rtl/bbs_pkg.sv
// bbs_pkg: shared types and constants of the bicubic bezier surface evaluator
// no dependencies; compile before the interfaces and modules

package bbs_pkg;

	// item kinds
	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_EVAL = 1'b1
	} action_t;

	// control net geometry
	localparam int NET_SIDE  = 4;
	localparam int NET_SLOTS = NET_SIDE * NET_SIDE;
	localparam int SLOT_BITS = $clog2(NET_SLOTS);

	// coordinate lanes
	localparam int CRD_X   = 0;
	localparam int CRD_Y   = 1;
	localparam int CRD_Z   = 2;
	localparam int NUM_CRD = 3;

	// y bias after reset: 0.25 with 8 fraction bits
	localparam int BIAS_RESET = 64;

endpackage

>>> rtl/bbs_if.sv
// bbs_item_if and bbs_result_if: valid/ready channels of the surface evaluator
// depends on bbs_pkg

interface bbs_item_if #(
	parameter int COORD_WIDTH = 16,
	parameter int PARAM_WIDTH = 16
) ();
	logic                                  valid;
	logic                                  ready;
	bbs_pkg::action_t                      action;
	logic [bbs_pkg::SLOT_BITS-1:0]         point_index;
	logic signed [COORD_WIDTH-1:0]         coord_x;
	logic signed [COORD_WIDTH-1:0]         coord_y;
	logic signed [COORD_WIDTH-1:0]         coord_z;
	logic [PARAM_WIDTH-1:0]                param_u;
	logic [PARAM_WIDTH-1:0]                param_v;

	modport source (
		output valid, action, point_index, coord_x, coord_y, coord_z, param_u, param_v,
		input  ready
	);
	modport sink (
		input  valid, action, point_index, coord_x, coord_y, coord_z, param_u, param_v,
		output ready
	);
endinterface

interface bbs_result_if #(
	parameter int COORD_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] surf_x;
	logic signed [COORD_WIDTH-1:0] surf_y;
	logic signed [COORD_WIDTH-1:0] surf_z;
	logic                          clipped;

	modport source (
		output valid, surf_x, surf_y, surf_z, clipped,
		input  ready
	);
	modport sink (
		input  valid, surf_x, surf_y, surf_z, clipped,
		output ready
	);
endinterface

>>> rtl/bicubic_bezier_surface_eval_top.sv
// bicubic_bezier_surface_eval_top: seven stage bicubic bezier patch evaluator
// depends on bbs_pkg, bbs_item_if and bbs_result_if

// Evaluates a bicubic Bezier patch from a 4x4 net of signed control points
// (8 fraction bits) at an unsigned parameter pair u, v. A load beat writes
// one control point and returns nothing; an evaluate beat returns one
// surface point, with start_y_bias added to y, every coordinate rounded half
// up and saturated, and clipped set when any coordinate saturated. The
// pipeline is seven registers deep: blend weights (two stages), pair weights,
// point products, two adder stages and a round/saturate stage that is the
// output register. One beat enters per clock when the sink does not stall;
// the sustained rate is then one beat per clock. Backpressure stalls only the
// stages that hold a beat, so bubbles are squeezed out. Loads travel down to
// the product stage and write the net there, which keeps them in order with
// evaluates. A net slot must be loaded before an evaluate reads it; there is
// no clearing pass. The user must write start_y_bias through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.

module bicubic_bezier_surface_eval_top #(
	parameter int COORD_WIDTH = 16,
	parameter int PARAM_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic signed [COORD_WIDTH-1:0] cfg_wdata,
	bbs_item_if.sink                      req,
	bbs_result_if.source                  rsp
);

	localparam int P  = PARAM_WIDTH;
	localparam int C  = COORD_WIDTH;
	localparam int BW = P + 2;          // weight width, holds up to 2^P with headroom
	localparam int MW = 2 * BW;         // raw weight product width
	localparam int PW = BW + 1 + C;     // signed weight times coordinate
	localparam int GW = PW + 2;         // sum of one row of four
	localparam int AW = PW + 5;         // full sum plus bias
	localparam int NS = bbs_pkg::NET_SIDE;
	localparam int NL = bbs_pkg::NET_SLOTS;
	localparam int NC = bbs_pkg::NUM_CRD;

	localparam logic [BW-1:0]        UNITY  = {2'b01, {P{1'b0}}};
	localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (C - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
	localparam logic signed [AW-1:0] HALF_S = AW'(1) <<< (P - 1);

	// unsigned round half up, drop P fraction bits
	function automatic logic [BW-1:0] rnd_u(input logic [MW-1:0] a);
		logic [MW:0] t;
		t = {1'b0, a} + ({{MW{1'b0}}, 1'b1} << (P - 1));
		return t[P +: BW];
	endfunction

	// pipeline handshake: a stage takes a beat when it is empty or draining
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !valid_s7 || rsp.ready;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign req.ready = en1;

	// y bias register
	logic signed [C-1:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= C'(bbs_pkg::BIAS_RESET);
		end else if (cfg_we) begin
			bias_q <= cfg_wdata;
		end
	end

	// load payload carried along stages 1 to 3
	bbs_pkg::action_t              act_s1, act_s2, act_s3;
	logic [bbs_pkg::SLOT_BITS-1:0] slot_s1, slot_s2, slot_s3;
	logic signed [C-1:0]           crd_s1 [NC];
	logic signed [C-1:0]           crd_s2 [NC];
	logic signed [C-1:0]           crd_s3 [NC];

	// valid bits; loads leave the pipe once they reach the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= req.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3 && (act_s3 == bbs_pkg::ACT_EVAL);
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1                <= req.action;
			slot_s1               <= req.point_index;
			crd_s1[bbs_pkg::CRD_X] <= req.coord_x;
			crd_s1[bbs_pkg::CRD_Y] <= req.coord_y;
			crd_s1[bbs_pkg::CRD_Z] <= req.coord_z;
		end
		if (en2) begin
			act_s2  <= act_s1;
			slot_s2 <= slot_s1;
			crd_s2  <= crd_s1;
		end
		if (en3) begin
			act_s3  <= act_s2;
			slot_s3 <= slot_s2;
			crd_s3  <= crd_s2;
		end
	end

	// stage 1: complements and squares, direction 0 is u, 1 is v
	logic [BW-1:0] par_s1 [2];
	logic [BW-1:0] cmp_s1 [2];
	logic [BW-1:0] sq_s1  [2];
	logic [BW-1:0] csq_s1 [2];

	// stage 2: the four cubic blend weights per direction
	logic [BW-1:0] blend_s2 [2][NS];

	for (genvar d = 0; d < 2; d++) begin : g_dir
		logic [BW-1:0] par_c, cmp_c;
		logic [MW-1:0] sq_m, csq_m;
		logic [MW-1:0] b0_m, b1_m, b2_m, b3_m;
		logic [BW-1:0] b1_r, b2_r;

		assign par_c = (d == 0) ? BW'(req.param_u) : BW'(req.param_v);
		assign cmp_c = UNITY - par_c;
		assign sq_m  = par_c * par_c;
		assign csq_m = cmp_c * cmp_c;

		always_ff @(posedge clk) begin
			if (en1) begin
				par_s1[d] <= par_c;
				cmp_s1[d] <= cmp_c;
				sq_s1[d]  <= rnd_u(sq_m);
				csq_s1[d] <= rnd_u(csq_m);
			end
		end

		assign b0_m = csq_s1[d] * cmp_s1[d];
		assign b1_m = csq_s1[d] * par_s1[d];
		assign b2_m = sq_s1[d] * cmp_s1[d];
		assign b3_m = sq_s1[d] * par_s1[d];
		assign b1_r = rnd_u(b1_m);
		assign b2_r = rnd_u(b2_m);

		always_ff @(posedge clk) begin
			if (en2) begin
				blend_s2[d][0] <= rnd_u(b0_m);
				blend_s2[d][1] <= b1_r + (b1_r << 1);
				blend_s2[d][2] <= b2_r + (b2_r << 1);
				blend_s2[d][3] <= rnd_u(b3_m);
			end
		end
	end

	// stage 3: pair weights, slot = u row times side plus v column
	logic [BW-1:0] wt_s3 [NL];

	for (genvar i = 0; i < NS; i++) begin : g_wrow
		for (genvar j = 0; j < NS; j++) begin : g_wcol
			logic [MW-1:0] pw_m;
			assign pw_m = blend_s2[0][i] * blend_s2[1][j];
			always_ff @(posedge clk) begin
				if (en3) wt_s3[i * NS + j] <= rnd_u(pw_m);
			end
		end
	end

	// control net, written by load beats as they enter stage 4
	logic signed [C-1:0] net_q [NL][NC];

	always_ff @(posedge clk) begin
		if (en4 && valid_s3 && (act_s3 == bbs_pkg::ACT_LOAD)) begin
			net_q[slot_s3] <= crd_s3;
		end
	end

	// stage 4: weight times control point, one multiplier per slot and lane
	logic signed [PW-1:0] prod_s4 [NC][NL];

	for (genvar c = 0; c < NC; c++) begin : g_plane
		for (genvar s = 0; s < NL; s++) begin : g_prod
			logic signed [PW-1:0] prod_c;
			assign prod_c = $signed({1'b0, wt_s3[s]}) * net_q[s][c];
			always_ff @(posedge clk) begin
				if (en4) prod_s4[c][s] <= prod_c;
			end
		end
	end

	// stage 5: row sums; stage 6: full sum plus bias; stage 7: round, saturate
	logic signed [GW-1:0] row_s5 [NC][NS];
	logic signed [AW-1:0] acc_s6 [NC];
	logic signed [C-1:0]  res_s7 [NC];
	logic [NC-1:0]        sat_c;

	for (genvar c = 0; c < NC; c++) begin : g_sum
		logic signed [AW-1:0] tot_c, bias_c, rnd_c;

		for (genvar i = 0; i < NS; i++) begin : g_row
			logic signed [GW-1:0] rs_c;
			always_comb begin
				rs_c = '0;
				for (int j = 0; j < NS; j++) begin
					rs_c = rs_c + GW'(prod_s4[c][i * NS + j]);
				end
			end
			always_ff @(posedge clk) begin
				if (en5) row_s5[c][i] <= rs_c;
			end
		end

		assign bias_c = (c == bbs_pkg::CRD_Y) ? (AW'(bias_q) <<< P) : '0;

		always_comb begin
			tot_c = bias_c;
			for (int i = 0; i < NS; i++) begin
				tot_c = tot_c + AW'(row_s5[c][i]);
			end
		end

		always_ff @(posedge clk) begin
			if (en6) acc_s6[c] <= tot_c;
		end

		// arithmetic shift floors, so adding one half rounds half up
		assign rnd_c    = (acc_s6[c] + HALF_S) >>> P;
		assign sat_c[c] = (rnd_c > SAT_HI) || (rnd_c < SAT_LO);

		always_ff @(posedge clk) begin
			if (en7) begin
				priority if (rnd_c > SAT_HI) begin
					res_s7[c] <= SAT_HI[C-1:0];
				end else if (rnd_c < SAT_LO) begin
					res_s7[c] <= SAT_LO[C-1:0];
				end else begin
					res_s7[c] <= rnd_c[C-1:0];
				end
			end
		end
	end

	logic clip_s7;

	always_ff @(posedge clk) begin
		if (en7) clip_s7 <= |sat_c;
	end

	assign rsp.valid   = valid_s7;
	assign rsp.surf_x  = res_s7[bbs_pkg::CRD_X];
	assign rsp.surf_y  = res_s7[bbs_pkg::CRD_Y];
	assign rsp.surf_z  = res_s7[bbs_pkg::CRD_Z];
	assign rsp.clipped = clip_s7;

endmodule

>>> rtl/bbs_checker.sv
// bbs_checker: port level checks of the surface evaluator, bound to the top level
// depends on bicubic_bezier_surface_eval_top and its interfaces

module bbs_checker #(
	parameter int COORD_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] surf_x,
	input logic signed [COORD_WIDTH-1:0] surf_y,
	input logic signed [COORD_WIDTH-1:0] surf_z,
	input logic                          clipped
);

	localparam logic signed [COORD_WIDTH-1:0] HI = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] LO = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	// a result beat stays offered until taken
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({surf_x, surf_y, surf_z, clipped}))
		else $error("result payload changed while stalled");

	// a draining output never blocks the input side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked although output drains");

	// a clipped result has a coordinate at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> surf_x == HI || surf_x == LO || surf_y == HI ||
			surf_y == LO || surf_z == HI || surf_z == LO)
		else $error("clipped set without a saturated coordinate");

endmodule

bind bicubic_bezier_surface_eval_top bbs_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_bbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.surf_x    (rsp.surf_x),
	.surf_y    (rsp.surf_y),
	.surf_z    (rsp.surf_z),
	.clipped   (rsp.clipped)
);
